// ===== design/gbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// gbpf_pkg
// shared widths for the goldbach prime pair finder
// ----------------------------------------------------------------------------
package gbpf_pkg;

  localparam int NW = 16;          // number width
  localparam int PW = NW - 1;      // small prime width
  localparam int DW = NW / 2 + 1;  // trial divisor and remainder width
  localparam int SW = NW + 1;      // divisor square width
  localparam int CW = $clog2(NW);  // bit counter width

  typedef logic [NW-1:0] num_t;
  typedef logic [DW-1:0] div_t;
  typedef logic [SW-1:0] sq_t;

endpackage

// ===== design/goldbach_prime_pair_finder_core.sv =====
// ----------------------------------------------------------------------------
// goldbach_prime_pair_finder_core
// finds the smallest prime p with p and number - p both prime
// ----------------------------------------------------------------------------
// operation: for each candidate, each trial divisor runs a bit-serial
//   remainder over all NW number bits; results are registered from the
//   final check, and odd numbers and numbers below four are dropped in idle
// throughput: one transaction at a time; busy stays high until the search ends
// reset: rst clears the controller to idle and drops valid and busy
// the result is shown for one cycle on valid; the receiver cannot stall
module goldbach_prime_pair_finder_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [gbpf_pkg::NW-1:0]  number,
  output logic                     valid,
  output logic [gbpf_pkg::NW-1:0]  echo_number,
  output logic [gbpf_pkg::PW-1:0]  small_prime,
  output logic [gbpf_pkg::NW-1:0]  large_prime
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_NEXT  = 3'd5;

  localparam gbpf_pkg::num_t NUM_FOUR = gbpf_pkg::num_t'(4);
  localparam gbpf_pkg::div_t DIV_TWO  = gbpf_pkg::div_t'(2);
  localparam gbpf_pkg::sq_t  SQ_FOUR  = gbpf_pkg::sq_t'(4);
  localparam gbpf_pkg::num_t CAND_TWO = gbpf_pkg::num_t'(2);
  localparam logic [gbpf_pkg::CW-1:0] CNT_LAST = gbpf_pkg::CW'(gbpf_pkg::NW - 1);

  logic [2:0]                 state;
  gbpf_pkg::num_t             held_number;
  gbpf_pkg::num_t             candidate;
  gbpf_pkg::num_t             value;
  gbpf_pkg::num_t             shifter;
  gbpf_pkg::div_t             trial_divisor;
  gbpf_pkg::div_t             remainder;
  gbpf_pkg::sq_t              square;
  logic [gbpf_pkg::CW-1:0]    bit_count;
  logic                       testing_second;

  gbpf_pkg::div_t             rem_shift;
  gbpf_pkg::div_t             rem_next;
  gbpf_pkg::num_t             candidate_next;
  logic [gbpf_pkg::NW:0]      twice_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    rem_shift      = {remainder[gbpf_pkg::DW-2:0], shifter[gbpf_pkg::NW-1]};
    rem_next       = (rem_shift >= trial_divisor) ? rem_shift - trial_divisor : rem_shift;
    candidate_next = candidate + gbpf_pkg::num_t'(1);
    twice_next     = {candidate_next, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      valid          <= 1'b0;
      testing_second <= 1'b0;
      held_number    <= '0;
      candidate      <= CAND_TWO;
      trial_divisor  <= DIV_TWO;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            held_number <= number;
            if (!number[0] && number >= NUM_FOUR) begin
              candidate      <= CAND_TWO;
              testing_second <= 1'b0;
              state          <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          value         <= testing_second ? held_number - candidate : candidate;
          trial_divisor <= DIV_TWO;
          square        <= SQ_FOUR;
          state         <= S_CHECK;
        end
        S_CHECK: begin
          if (square > {1'b0, value}) begin
            // value is prime
            if (!testing_second) begin
              testing_second <= 1'b1;
              state          <= S_SETUP;
            end else begin
              valid          <= 1'b1;
              echo_number    <= held_number;
              small_prime    <= candidate[gbpf_pkg::PW-1:0];
              large_prime    <= value;
              testing_second <= 1'b0;
              candidate      <= CAND_TWO;
              trial_divisor  <= DIV_TWO;
              state          <= S_IDLE;
            end
          end else begin
            shifter   <= value;
            remainder <= '0;
            bit_count <= '0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          remainder <= rem_next;
          shifter   <= {shifter[gbpf_pkg::NW-2:0], 1'b0};
          bit_count <= bit_count + gbpf_pkg::CW'(1);
          if (bit_count == CNT_LAST) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (remainder == '0) begin
            state <= S_NEXT;
          end else begin
            trial_divisor <= trial_divisor + gbpf_pkg::div_t'(1);
            square        <= square + gbpf_pkg::sq_t'({trial_divisor, 1'b1});
            state         <= S_CHECK;
          end
        end
        S_NEXT: begin
          testing_second <= 1'b0;
          if (twice_next > {1'b0, held_number}) begin
            candidate     <= CAND_TWO;
            trial_divisor <= DIV_TWO;
            state         <= S_IDLE;
          end else begin
            candidate <= candidate_next;
            state     <= S_SETUP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/gbpf_checker.sv =====
// ----------------------------------------------------------------------------
// gbpf_checker
// port-level checks for the goldbach prime pair finder
// ----------------------------------------------------------------------------
module gbpf_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [gbpf_pkg::NW-1:0]  number,
  input logic                     valid,
  input logic [gbpf_pkg::NW-1:0]  echo_number,
  input logic [gbpf_pkg::PW-1:0]  small_prime,
  input logic [gbpf_pkg::NW-1:0]  large_prime
);

  // a result ends the search
  assert property (@(posedge clk) disable iff (rst) valid |-> !busy)
    else $error("result while busy");

  // one pulse per transaction
  assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("result strobe longer than one cycle");

  // the pair adds up to the number
  assert property (@(posedge clk) disable iff (rst)
    valid |-> ({1'b0, large_prime} + {2'b0, small_prime}) == {1'b0, echo_number})
    else $error("pair does not sum to number");

  // only even numbers are split, small prime at most half
  assert property (@(posedge clk) disable iff (rst)
    valid |-> (!echo_number[0] && {1'b0, small_prime} <= large_prime))
    else $error("bad pair ordering or odd number");

  // an odd number is dropped at once
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && number[0]) |=> (!busy && !valid))
    else $error("odd number started a search");

endmodule

bind goldbach_prime_pair_finder_core gbpf_checker u_gbpf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .number      (number),
  .valid       (valid),
  .echo_number (echo_number),
  .small_prime (small_prime),
  .large_prime (large_prime)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// goldbach prime pair finder testbench
// Sends unsigned numbers through the start/busy handshake and works out
// independently the smallest prime p for which p and number - p are both
// prime. Results seen on the valid strobe are compared in order, field by
// field, against those pairs. Odd numbers and numbers without a pair give
// nothing. Small numbers make up most of the traffic and full range values
// the rest. The sender idles at varying rates between transactions.
// ----------------------------------------------------------------------------
module testbench;

  class pair_ledger;
    typedef struct {
      gbpf_pkg::num_t          number;
      logic [gbpf_pkg::PW-1:0] small_p;
      gbpf_pkg::num_t          large_p;
    } prime_pair_t;

    prime_pair_t awaited_pairs[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function bit is_prime_trial(int unsigned v);
      if (v < 2) return 1'b0;
      for (int unsigned d = 2; d * d <= v; d++) begin
        if (v % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    static function bit find_prime_pair(gbpf_pkg::num_t n, output prime_pair_t pair);
      int unsigned value;
      value = n;
      pair = '{default: '0};
      if (n[0]) return 1'b0;
      for (int unsigned p = 2; 2 * p <= value; p++) begin
        if (is_prime_trial(p) && is_prime_trial(value - p)) begin
          pair.number  = n;
          pair.small_p = gbpf_pkg::PW'(p);
          pair.large_p = gbpf_pkg::num_t'(value - p);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_number(gbpf_pkg::num_t n);
      prime_pair_t pair;
      if (find_prime_pair(n, pair)) awaited_pairs.push_back(pair);
    endfunction

    function int unsigned pending();
      return awaited_pairs.size();
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < 100) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_pair(gbpf_pkg::num_t echo, logic [gbpf_pkg::PW-1:0] sp,
                    gbpf_pkg::num_t lp);
      prime_pair_t want;
      if (awaited_pairs.size() == 0) begin
        flag_mismatch($sformatf("unexpected pair %0d = %0d + %0d", echo, sp, lp));
        return;
      end
      want = awaited_pairs.pop_front();
      if (echo !== want.number)
        flag_mismatch($sformatf("echo_number %0d, want %0d", echo, want.number));
      if (sp !== want.small_p)
        flag_mismatch($sformatf("small_prime %0d, want %0d (number %0d)",
                                sp, want.small_p, want.number));
      if (lp !== want.large_p)
        flag_mismatch($sformatf("large_prime %0d, want %0d (number %0d)",
                                lp, want.large_p, want.number));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  gbpf_pkg::num_t          number = '0;
  logic                    busy;
  logic                    valid;
  gbpf_pkg::num_t          echo_number;
  logic [gbpf_pkg::PW-1:0] small_prime;
  gbpf_pkg::num_t          large_prime;

  pair_ledger ledger = new();

  goldbach_prime_pair_finder_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .number      (number),
    .valid       (valid),
    .echo_number (echo_number),
    .small_prime (small_prime),
    .large_prime (large_prime)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && valid) ledger.check_pair(echo_number, small_prime, large_prime);
  end

  // start stays high after acceptance; the caller lowers it or sends again
  task issue_number(gbpf_pkg::num_t value);
    start  <= 1'b1;
    number <= value;
    do @(posedge clk); while (busy);
    ledger.note_number(value);
  endtask

  task sender_gap(int unsigned pct);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(600, 1) : $urandom_range(6, 1);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain_pairs();
    start <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0 || busy);
  endtask

  function automatic gbpf_pkg::num_t random_number();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return gbpf_pkg::num_t'($urandom_range(65535));
    else if (r < 25) return gbpf_pkg::num_t'($urandom_range(2047) | 1);
    else if (r < 32) return gbpf_pkg::num_t'($urandom_range(15));
    else return gbpf_pkg::num_t'($urandom_range(2047) & 32'hfffe);
  endfunction

  initial begin
    gbpf_pkg::num_t directed_list[$];
    int unsigned idle_pct;

    directed_list = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd8, 16'd4, 16'd12,
      16'd98, 16'd128, 16'd65535, 16'd65534, 16'd65532, 16'd65530, 16'd32768,
      16'd21846, 16'd43690, 16'd1024, 16'd2, 16'd7
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_list[i]) issue_number(directed_list[i]);
    drain_pairs();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 18 : (phase == 1) ? 45 : 0;
      for (int i = 0; i < 40; i++) begin
        sender_gap(idle_pct);
        issue_number(random_number());
        if (phase == 1 && i == 20) drain_pairs();
      end
    end

    drain_pairs();
    repeat (64) @(posedge clk);
    if (ledger.pending() != 0)
      ledger.flag_mismatch($sformatf("%0d pairs never arrived", ledger.pending()));

    if (ledger.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
